>>> sv/tsb_pkg.sv
// Shared types, opcodes and constants of the text screen blitter.
package tsb_pkg;

	// Field widths of one command item and one result item
	localparam int OP_W    = 3;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 3;
	localparam int CUR_W   = 11;

	// Widths that hold any row or column sum over the legal screen sizes
	// (height up to 128, width up to 256)
	localparam int ROWX_W = 8;
	localparam int COLX_W = 9;

	// Cell contents after reset
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [CHAR_W-1:0] BLANK_ATTR = 8'h0F;

	typedef enum logic [OP_W-1:0] {
		OP_PUT    = 3'd0,
		OP_FILL   = 3'd1,
		OP_COPY   = 3'd2,
		OP_CURSOR = 3'd3,
		OP_READ   = 3'd4
	} tsb_op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_step;
		logic load;
		logic setup;
		logic issue;
		logic finish;
	} tsb_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic need_run;
		logic last;
	} tsb_stat_t;

endpackage

>>> sv/tsb_cmd_if.sv
// Command channel: valid/ready handshake with one command item as payload.
interface tsb_cmd_if import tsb_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      opcode;
	logic [ROW_W-1:0]     row;
	logic [COL_W-1:0]     col;
	logic [ROW_W-1:0]     top_row;
	logic [COL_W-1:0]     left_col;
	logic [ROW_W-1:0]     bottom_row;
	logic [COL_W-1:0]     right_col;
	logic [CHAR_W-1:0]    char_in;
	logic [COLOR_W-1:0]   fg_color;
	logic [COLOR_W-1:0]   bg_color;

	modport source (
		output valid, opcode, row, col, top_row, left_col, bottom_row, right_col,
		output char_in, fg_color, bg_color,
		input  ready
	);
	modport sink (
		input  valid, opcode, row, col, top_row, left_col, bottom_row, right_col,
		input  char_in, fg_color, bg_color,
		output ready
	);
endinterface

>>> sv/tsb_rsp_if.sv
// Result channel: valid/ready handshake with one result item as payload.
interface tsb_rsp_if import tsb_pkg::*;;
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  char_out;
	logic [CHAR_W-1:0]  attr_out;
	logic [CUR_W-1:0]   cursor_offset;
	logic               status;

	modport source (
		output valid, char_out, attr_out, cursor_offset, status,
		input  ready
	);
	modport sink (
		input  valid, char_out, attr_out, cursor_offset, status,
		output ready
	);
endinterface

>>> sv/tsb_dp.sv
// Datapath: command latch, range checks, cell walkers, screen memory, result.
module tsb_dp import tsb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tsb_ctl_t            ctl,
	output tsb_stat_t           stat,
	input  logic [OP_W-1:0]     opcode,
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W-1:0]    col,
	input  logic [ROW_W-1:0]    top_row,
	input  logic [COL_W-1:0]    left_col,
	input  logic [ROW_W-1:0]    bottom_row,
	input  logic [COL_W-1:0]    right_col,
	input  logic [CHAR_W-1:0]   char_in,
	input  logic [COLOR_W-1:0]  fg_color,
	input  logic [COLOR_W-1:0]  bg_color,
	output logic [CHAR_W-1:0]   char_out,
	output logic [CHAR_W-1:0]   attr_out,
	output logic [CUR_W-1:0]    cursor_offset,
	output logic                status
);

	localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SUM_W  = (AW > CUR_W) ? AW : CUR_W;
	localparam int PROD_W = ROWX_W + COLX_W;
	localparam int WORD_W = 2 * CHAR_W;
	localparam int PAD_W  = CHAR_W - 2 * COLOR_W;

	localparam logic [ROWX_W-1:0] HEIGHT_X  = ROWX_W'(SCREEN_HEIGHT);
	localparam logic [COLX_W-1:0] WIDTH_X   = COLX_W'(SCREEN_WIDTH);
	localparam logic [AW-1:0]     WIDTH_A   = AW'(SCREEN_WIDTH);
	localparam logic [AW-1:0]     LAST_CELL = AW'(CELLS - 1);

	// Latched command item
	logic [OP_W-1:0]    op_q;
	logic [ROW_W-1:0]   row_q, top_q, bottom_q;
	logic [COL_W-1:0]   col_q, left_q, right_q;
	logic [CHAR_W-1:0]  char_q, attr_q;

	// Walker state
	logic [AW-1:0]      src_base_q, dst_base_q;
	logic [COLX_W-1:0]  src_col_q, dst_col_q, src_col0_q, dst_col0_q;
	logic               row_fwd_q, col_fwd_q;
	logic [ROW_W-1:0]   row_cnt_q;
	logic [COL_W-1:0]   col_cnt_q, cols_q;

	// Clear pass, copy write lag, memory
	logic [AW-1:0]      clr_addr_q;
	logic               wr_s1;
	logic [AW-1:0]      wr_addr_s1;
	logic [WORD_W-1:0]  mem [CELLS];
	logic [WORD_W-1:0]  rdata_q;
	logic [CUR_W-1:0]   cursor_q;
	logic [CHAR_W-1:0]  res_char_q, res_attr_q;
	logic               res_status_q;

	// Decode results
	logic               on_screen, rect_ok, fits, empty, down, rightward;
	logic [ROW_W-1:0]   nrow;
	logic [COL_W-1:0]   ncol;
	logic               err, need_run, row_fwd, col_fwd;
	logic [ROWX_W-1:0]  src_row, dst_row;
	logic [COLX_W-1:0]  src_col, dst_col;
	logic [ROW_W-1:0]   rows;
	logic [COL_W-1:0]   cols;
	logic [PROD_W-1:0]  src_prod, dst_prod;
	logic [AW-1:0]      src_addr, dst_addr;
	logic [SUM_W-1:0]   cursor_ext;
	logic               rd_en, direct_wr, we;
	logic [AW-1:0]      waddr;
	logic [WORD_W-1:0]  wdata;

	// Latch the command item on accept
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q     <= opcode;
			row_q    <= row;
			col_q    <= col;
			top_q    <= top_row;
			left_q   <= left_col;
			bottom_q <= bottom_row;
			right_q  <= right_col;
			char_q   <= char_in;
			attr_q   <= {{PAD_W{1'b0}}, bg_color, fg_color};
		end
	end

	// Range checks on the latched item
	assign nrow      = bottom_q - top_q;
	assign ncol      = right_q - left_q;
	assign on_screen = (ROWX_W'(row_q) < HEIGHT_X) && (COLX_W'(col_q) < WIDTH_X);
	assign rect_ok   = (top_q <= bottom_q) && (left_q <= right_q) &&
	                   (ROWX_W'(bottom_q) <= HEIGHT_X) && (COLX_W'(right_q) <= WIDTH_X);
	assign fits      = (ROWX_W'(row_q) + ROWX_W'(nrow) <= HEIGHT_X) &&
	                   (COLX_W'(col_q) + COLX_W'(ncol) <= WIDTH_X);
	assign empty     = (nrow == '0) || (ncol == '0);
	assign down      = row_q < top_q;
	assign rightward = col_q < left_q;

	// Decode walk extents and starting corners per opcode
	always_comb begin
		err      = 1'b1;
		need_run = 1'b0;
		src_row  = ROWX_W'(row_q);
		dst_row  = ROWX_W'(row_q);
		src_col  = COLX_W'(col_q);
		dst_col  = COLX_W'(col_q);
		row_fwd  = 1'b1;
		col_fwd  = 1'b1;
		rows     = ROW_W'(1);
		cols     = COL_W'(1);
		unique case (op_q)
			OP_PUT: begin
				err      = !on_screen;
				need_run = on_screen;
			end
			OP_FILL: begin
				err      = !rect_ok;
				need_run = rect_ok && !empty;
				dst_row  = ROWX_W'(top_q);
				dst_col  = COLX_W'(left_q);
				rows     = nrow;
				cols     = ncol;
			end
			OP_COPY: begin
				err      = !(rect_ok && fits);
				need_run = rect_ok && fits && !empty;
				rows     = nrow;
				cols     = ncol;
				row_fwd  = down;
				col_fwd  = rightward;
				// walk from the corner that is read before it is overwritten
				src_row  = down ? ROWX_W'(top_q) : ROWX_W'(bottom_q) - ROWX_W'(1);
				dst_row  = down ? ROWX_W'(row_q)
				                : ROWX_W'(row_q) + ROWX_W'(nrow) - ROWX_W'(1);
				src_col  = rightward ? COLX_W'(left_q) : COLX_W'(right_q) - COLX_W'(1);
				dst_col  = rightward ? COLX_W'(col_q)
				                     : COLX_W'(col_q) + COLX_W'(ncol) - COLX_W'(1);
			end
			OP_CURSOR: begin
				err = !on_screen;
			end
			OP_READ: begin
				err      = !on_screen;
				need_run = on_screen;
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	// Row bases of the starting corners
	assign src_prod = PROD_W'(src_row) * PROD_W'(WIDTH_X);
	assign dst_prod = PROD_W'(dst_row) * PROD_W'(WIDTH_X);

	assign src_addr = src_base_q + AW'(src_col_q);
	assign dst_addr = dst_base_q + AW'(dst_col_q);

	// Load and advance the walkers
	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			src_base_q <= AW'(src_prod);
			dst_base_q <= AW'(dst_prod);
			src_col_q  <= src_col;
			dst_col_q  <= dst_col;
			src_col0_q <= src_col;
			dst_col0_q <= dst_col;
			row_fwd_q  <= row_fwd;
			col_fwd_q  <= col_fwd;
			row_cnt_q  <= rows;
			col_cnt_q  <= cols;
			cols_q     <= cols;
		end else if (ctl.issue) begin
			if (col_cnt_q == COL_W'(1)) begin
				// wrap to the next row
				col_cnt_q  <= cols_q;
				row_cnt_q  <= row_cnt_q - ROW_W'(1);
				src_col_q  <= src_col0_q;
				dst_col_q  <= dst_col0_q;
				src_base_q <= row_fwd_q ? src_base_q + WIDTH_A : src_base_q - WIDTH_A;
				dst_base_q <= row_fwd_q ? dst_base_q + WIDTH_A : dst_base_q - WIDTH_A;
			end else begin
				col_cnt_q <= col_cnt_q - COL_W'(1);
				src_col_q <= col_fwd_q ? src_col_q + COLX_W'(1) : src_col_q - COLX_W'(1);
				dst_col_q <= col_fwd_q ? dst_col_q + COLX_W'(1) : dst_col_q - COLX_W'(1);
			end
		end
	end

	// Clear counter, copy write lag and cursor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			wr_s1      <= 1'b0;
			cursor_q   <= '0;
		end else begin
			if (ctl.clr_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			wr_s1 <= ctl.issue && (op_q == OP_COPY);
			if (ctl.finish && !err && (op_q == OP_CURSOR)) begin
				cursor_q <= cursor_ext[CUR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= dst_addr;
	end

	// Memory port selection
	assign rd_en     = ctl.issue && ((op_q == OP_COPY) || (op_q == OP_READ));
	assign direct_wr = ctl.issue && ((op_q == OP_PUT) || (op_q == OP_FILL));
	assign we        = ctl.clr_step || direct_wr || wr_s1;

	always_comb begin
		if (ctl.clr_step) begin
			waddr = clr_addr_q;
			wdata = {BLANK_CHAR, BLANK_ATTR};
		end else if (wr_s1) begin
			waddr = wr_addr_s1;
			wdata = rdata_q;
		end else begin
			waddr = dst_addr;
			wdata = {char_q, attr_q};
		end
	end

	// Screen memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[src_addr];
		end
	end

	// Result register
	assign cursor_ext = SUM_W'(dst_addr);

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			if (!err && (op_q == OP_READ)) begin
				res_char_q <= rdata_q[WORD_W-1:CHAR_W];
				res_attr_q <= rdata_q[CHAR_W-1:0];
			end else begin
				res_char_q <= '0;
				res_attr_q <= '0;
			end
			res_status_q <= err;
		end
	end

	assign stat.clr_last = clr_addr_q == LAST_CELL;
	assign stat.need_run = need_run;
	assign stat.last     = (row_cnt_q == ROW_W'(1)) && (col_cnt_q == COL_W'(1));

	assign char_out      = res_char_q;
	assign attr_out      = res_attr_q;
	assign cursor_offset = cursor_q;
	assign status        = res_status_q;

endmodule

>>> sv/tsb_ctrl.sv
// Controller: sequences clear pass, command setup, cell walk and result hand-off.
module tsb_ctrl import tsb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  logic       rsp_ready,
	output logic       rsp_valid,
	input  tsb_stat_t  stat,
	output tsb_ctl_t   ctl
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SETUP,
		S_RUN,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	// Drive datapath commands from the current state
	always_comb begin
		ctl          = '0;
		ctl.clr_step = state_q == S_CLEAR;
		ctl.load     = (state_q == S_IDLE) && cmd_valid;
		ctl.setup    = state_q == S_SETUP;
		ctl.issue    = state_q == S_RUN;
		ctl.finish   = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);
	end

	assign cmd_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

	// Advance state, hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					state_q <= stat.need_run ? S_RUN : S_FIN;
				end
				S_RUN: begin
					if (stat.last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (ctl.finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/text_screen_blitter_core.sv
// Text screen blitter top level: controller plus datapath on two handshake channels.
// After reset the screen store is swept to blank cells (space, attribute 0x0F), one
// cell a cycle over all SCREEN_WIDTH*SCREEN_HEIGHT cells, with cmd.ready low.
// Afterwards each command item is accepted in S_IDLE and checked and set up in
// S_SETUP; set cursor, rejected commands and empty rectangles then finish at once,
// put and read walk a single cell, and fill and copy walk their cells at one cell a
// cycle through the single write and read port of the screen memory. A copy writes
// each cell in the cycle after it reads the source cell. A finished result waits in
// the output register while the next command item is accepted; cursor_offset shows
// the cursor as left by the command of that result.
module text_screen_blitter_core import tsb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	tsb_cmd_if.sink   cmd,
	tsb_rsp_if.source rsp
);

	tsb_ctl_t  ctl;
	tsb_stat_t stat;

	tsb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.stat      (stat),
		.ctl       (ctl)
	);

	tsb_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.opcode        (cmd.opcode),
		.row           (cmd.row),
		.col           (cmd.col),
		.top_row       (cmd.top_row),
		.left_col      (cmd.left_col),
		.bottom_row    (cmd.bottom_row),
		.right_col     (cmd.right_col),
		.char_in       (cmd.char_in),
		.fg_color      (cmd.fg_color),
		.bg_color      (cmd.bg_color),
		.char_out      (rsp.char_out),
		.attr_out      (rsp.attr_out),
		.cursor_offset (rsp.cursor_offset),
		.status        (rsp.status)
	);

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for text_screen_blitter_core: directed and random commands.
`timescale 1ns / 100ps

module tb_top import tsb_pkg::*; ;

	localparam int SCR_W     = 80;
	localparam int SCR_H     = 25;
	localparam int SCR_CELLS = SCR_W * SCR_H;

	localparam logic ST_DONE   = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   top_row;
		logic [COL_W-1:0]   left_col;
		logic [ROW_W-1:0]   bottom_row;
		logic [COL_W-1:0]   right_col;
		logic [CHAR_W-1:0]  char_in;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
	} screen_cmd_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic [CHAR_W-1:0] attr_out;
		logic [CUR_W-1:0]  cursor_offset;
		logic              status;
	} screen_rsp_t;

	logic clk;
	logic arst_n;

	tsb_cmd_if cmd_ch ();
	tsb_rsp_if rsp_ch ();

	text_screen_blitter_core #(
		.SCREEN_WIDTH  (SCR_W),
		.SCREEN_HEIGHT (SCR_H)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Mirror of the screen store and cursor
	logic [CHAR_W-1:0] shadow_chars [SCR_CELLS];
	logic [CHAR_W-1:0] shadow_attrs [SCR_CELLS];
	logic [CUR_W-1:0]  shadow_cursor;

	screen_rsp_t awaited_replies [$];
	int          fail_count;
	bit          sender_idle;
	bit          receiver_idle;
	int          hold_left;
	int          stall_left;

	// Clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Apply one accepted command to the mirror and return the reply it should give
	function automatic screen_rsp_t apply_to_screen(input screen_cmd_t c);
		screen_rsp_t       r;
		logic [CHAR_W-1:0] attr;
		logic [CHAR_W-1:0] src_chars [SCR_CELLS];
		logic [CHAR_W-1:0] src_attrs [SCR_CELLS];
		int                nrow, ncol, k, dst, src;
		bit                on_screen, rect_good;
		r          = '0;
		r.status   = ST_REJECT;
		attr       = CHAR_W'(c.fg_color) + CHAR_W'(c.bg_color) * 8'd8;
		on_screen  = c.row < SCR_H && c.col < SCR_W;
		rect_good  = c.top_row <= c.bottom_row && c.left_col <= c.right_col &&
		             c.bottom_row <= SCR_H && c.right_col <= SCR_W;
		nrow       = int'(c.bottom_row) - int'(c.top_row);
		ncol       = int'(c.right_col) - int'(c.left_col);
		case (c.opcode)
			OP_PUT: begin
				if (on_screen) begin
					k = c.row * SCR_W + c.col;
					shadow_chars[k] = c.char_in;
					shadow_attrs[k] = attr;
					r.status = ST_DONE;
				end
			end
			OP_FILL: begin
				if (rect_good) begin
					for (int y = int'(c.top_row); y < int'(c.bottom_row); y++)
						for (int x = int'(c.left_col); x < int'(c.right_col); x++) begin
							shadow_chars[y * SCR_W + x] = c.char_in;
							shadow_attrs[y * SCR_W + x] = attr;
						end
					r.status = ST_DONE;
				end
			end
			OP_COPY: begin
				// Reading from a snapshot equals the overlap-safe ordered walk
				if (rect_good && c.row + nrow <= SCR_H && c.col + ncol <= SCR_W) begin
					src_chars = shadow_chars;
					src_attrs = shadow_attrs;
					for (int y = 0; y < nrow; y++)
						for (int x = 0; x < ncol; x++) begin
							dst = (c.row + y) * SCR_W + c.col + x;
							src = (c.top_row + y) * SCR_W + c.left_col + x;
							shadow_chars[dst] = src_chars[src];
							shadow_attrs[dst] = src_attrs[src];
						end
					r.status = ST_DONE;
				end
			end
			OP_CURSOR: begin
				if (on_screen) begin
					shadow_cursor = CUR_W'(c.row * SCR_W + c.col);
					r.status = ST_DONE;
				end
			end
			OP_READ: begin
				if (on_screen) begin
					k = c.row * SCR_W + c.col;
					r.char_out = shadow_chars[k];
					r.attr_out = shadow_attrs[k];
					r.status = ST_DONE;
				end
			end
			default: ;
		endcase
		r.cursor_offset = shadow_cursor;
		return r;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap(input bit enabled);
		int roll;
		roll = $urandom_range(0, 99);
		if (!enabled || roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int clamp_to(input int v, input int lo, input int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic screen_cmd_t make_cmd(input logic [OP_W-1:0] op, input int row, col,
			top, left, bottom, right, ch, fg, bg);
		screen_cmd_t c;
		c.opcode     = op;
		c.row        = ROW_W'(row);
		c.col        = COL_W'(col);
		c.top_row    = ROW_W'(top);
		c.left_col   = COL_W'(left);
		c.bottom_row = ROW_W'(bottom);
		c.right_col  = COL_W'(right);
		c.char_in    = CHAR_W'(ch);
		c.fg_color   = COLOR_W'(fg);
		c.bg_color   = COLOR_W'(bg);
		return c;
	endfunction

	// Random command: mostly well-formed small rectangles, some noise and off-screen cases
	function automatic screen_cmd_t rand_cmd();
		screen_cmd_t c;
		int          pick, h, w;
		c    = screen_cmd_t'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick >= 92)
			return c;
		if (pick < 18)
			c.opcode = OP_PUT;
		else if (pick < 38)
			c.opcode = OP_FILL;
		else if (pick < 62)
			c.opcode = OP_COPY;
		else if (pick < 72)
			c.opcode = OP_CURSOR;
		else
			c.opcode = OP_READ;
		if (c.opcode == OP_FILL || c.opcode == OP_COPY) begin
			if ($urandom_range(0, 39) == 0) begin
				h = $urandom_range(0, SCR_H);
				w = $urandom_range(0, SCR_W);
			end else begin
				h = $urandom_range(0, 4);
				w = $urandom_range(0, 10);
			end
			if ($urandom_range(0, 9) != 0) begin
				c.top_row    = ROW_W'($urandom_range(0, SCR_H - h));
				c.bottom_row = ROW_W'(int'(c.top_row) + h);
				c.left_col   = COL_W'($urandom_range(0, SCR_W - w));
				c.right_col  = COL_W'(int'(c.left_col) + w);
			end
			if (c.opcode == OP_COPY) begin
				if ($urandom_range(0, 1) == 1) begin
					// land near the source so that the two overlap
					c.row = ROW_W'(clamp_to(int'(c.top_row) + $urandom_range(0, 4) - 2,
						0, SCR_H - h));
					c.col = COL_W'(clamp_to(int'(c.left_col) + $urandom_range(0, 6) - 3,
						0, SCR_W - w));
				end else begin
					c.row = ROW_W'($urandom_range(0, SCR_H - h));
					c.col = COL_W'($urandom_range(0, SCR_W - w));
				end
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 1) == 1)
						c.row = ROW_W'($urandom_range(SCR_H - h + 1, 31));
					else
						c.col = COL_W'($urandom_range(SCR_W - w + 1, 127));
				end
			end
		end else if ($urandom_range(0, 9) != 0) begin
			c.row = ROW_W'($urandom_range(0, SCR_H - 1));
			c.col = COL_W'($urandom_range(0, SCR_W - 1));
		end
		return c;
	endfunction

	// Offer one command item; called and returns at a falling edge, valid left high
	task automatic send_cmd(input screen_cmd_t c);
		int gap;
		gap = pick_gap(sender_idle);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.opcode     <= c.opcode;
		cmd_ch.row        <= c.row;
		cmd_ch.col        <= c.col;
		cmd_ch.top_row    <= c.top_row;
		cmd_ch.left_col   <= c.left_col;
		cmd_ch.bottom_row <= c.bottom_row;
		cmd_ch.right_col  <= c.right_col;
		cmd_ch.char_in    <= c.char_in;
		cmd_ch.fg_color   <= c.fg_color;
		cmd_ch.bg_color   <= c.bg_color;
		cmd_ch.valid      <= 1'b1;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		awaited_replies.push_back(apply_to_screen(c));
		@(negedge clk);
	endtask

	// Drop valid and wait until every reply is back
	task automatic drain_replies();
		cmd_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(negedge clk);
	endtask

	// Receiver: random stalls, plus a long hold when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			stall_left = pick_gap(receiver_idle);
		end
	end

	task automatic report_field(input string name, input int want, input int got);
		$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
		fail_count++;
	endtask

	// Compare each reply with the oldest expectation
	always @(posedge clk) begin : check_replies
		screen_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_replies.size() == 0) begin
				$display("%0t: reply with none expected: char 0x%0h attr 0x%0h cursor %0d status %0b",
					$time, rsp_ch.char_out, rsp_ch.attr_out, rsp_ch.cursor_offset, rsp_ch.status);
				fail_count++;
			end else begin
				want = awaited_replies.pop_front();
				if (rsp_ch.char_out !== want.char_out)
					report_field("char_out", int'(want.char_out), int'(rsp_ch.char_out));
				if (rsp_ch.attr_out !== want.attr_out)
					report_field("attr_out", int'(want.attr_out), int'(rsp_ch.attr_out));
				if (rsp_ch.cursor_offset !== want.cursor_offset)
					report_field("cursor_offset", int'(want.cursor_offset),
						int'(rsp_ch.cursor_offset));
				if (rsp_ch.status !== want.status)
					report_field("status", int'(want.status), int'(rsp_ch.status));
			end
		end
	end

	// Single-cell commands, off-screen rejects and unknown opcodes
	task automatic test_single_cells();
		send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_PUT, 0, 0, 31, 127, 31, 127, 8'hFF, 7, 7));
		send_cmd(make_cmd(OP_PUT, SCR_H - 1, SCR_W - 1, 0, 0, 0, 0, 8'h00, 0, 0));
		send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_READ, SCR_H - 1, SCR_W - 1, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_PUT, SCR_H, 0, 0, 0, 0, 0, 8'h55, 3, 4));
		send_cmd(make_cmd(OP_PUT, 31, 127, 0, 0, 0, 0, 8'hAA, 5, 2));
		send_cmd(make_cmd(OP_CURSOR, SCR_H - 1, SCR_W - 1, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_CURSOR, 0, SCR_W, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_READ, SCR_H, SCR_W - 1, 0, 0, 0, 0, 0, 0, 0));
		for (int op = OP_READ + 1; op < 2 ** OP_W; op++)
			send_cmd(make_cmd(OP_W'(op), 3, 3, 0, 0, 5, 5, 8'h33, 1, 1));
		send_cmd(make_cmd(OP_CURSOR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// Full, empty and malformed rectangles; overlapping and off-screen copies
	task automatic test_rectangles();
		send_cmd(make_cmd(OP_FILL, 0, 0, 0, 0, SCR_H, SCR_W, 8'h41, 2, 5));
		send_cmd(make_cmd(OP_FILL, 0, 0, 5, 5, 5, 9, 8'h42, 1, 1));
		send_cmd(make_cmd(OP_FILL, 0, 0, 10, 0, 9, 5, 8'h43, 1, 1));
		send_cmd(make_cmd(OP_FILL, 0, 0, 0, 10, 5, 9, 8'h43, 1, 1));
		send_cmd(make_cmd(OP_FILL, 0, 0, 0, 0, SCR_H + 1, 5, 8'h43, 1, 1));
		send_cmd(make_cmd(OP_FILL, 0, 0, 0, 0, 5, SCR_W + 1, 8'h43, 1, 1));
		send_cmd(make_cmd(OP_FILL, 0, 0, 2, 2, 6, 7, 8'h44, 6, 3));
		send_cmd(make_cmd(OP_PUT, 3, 3, 0, 0, 0, 0, 8'h2A, 7, 0));
		send_cmd(make_cmd(OP_COPY, 3, 4, 2, 2, 6, 7, 0, 0, 0));
		send_cmd(make_cmd(OP_COPY, 1, 0, 2, 2, 6, 7, 0, 0, 0));
		send_cmd(make_cmd(OP_COPY, SCR_H - 3, 0, 2, 2, 6, 7, 0, 0, 0));
		send_cmd(make_cmd(OP_COPY, 0, SCR_W - 4, 2, 2, 6, 7, 0, 0, 0));
		send_cmd(make_cmd(OP_COPY, 10, 10, 4, 4, 4, 8, 0, 0, 0));
		send_cmd(make_cmd(OP_COPY, 0, 0, 0, 0, SCR_H, SCR_W, 0, 0, 0));
		send_cmd(make_cmd(OP_READ, 2, 3, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) send_cmd(rand_cmd());
	endtask

	// Hold the receiver off long enough for the block to stall its input
	task automatic test_back_pressure();
		sender_idle = 1'b0;
		hold_left   = 300;
		repeat (12) send_cmd(rand_cmd());
		sender_idle = 1'b1;
	endtask

	// Pause the sender until every reply is back, then resume
	task automatic test_drain_pause();
		repeat (10) send_cmd(rand_cmd());
		drain_replies();
		repeat (10) send_cmd(rand_cmd());
	endtask

	// Back-to-back traffic with no gaps on either side
	task automatic test_no_idle();
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		repeat (40) send_cmd(rand_cmd());
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
	endtask

	initial begin
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.opcode     = '0;
		cmd_ch.row        = '0;
		cmd_ch.col        = '0;
		cmd_ch.top_row    = '0;
		cmd_ch.left_col   = '0;
		cmd_ch.bottom_row = '0;
		cmd_ch.right_col  = '0;
		cmd_ch.char_in    = '0;
		cmd_ch.fg_color   = '0;
		cmd_ch.bg_color   = '0;
		rsp_ch.ready      = 1'b0;
		fail_count        = 0;
		hold_left         = 0;
		stall_left        = 0;
		sender_idle       = 1'b1;
		receiver_idle     = 1'b1;
		shadow_cursor     = '0;
		for (int k = 0; k < SCR_CELLS; k++) begin
			shadow_chars[k] = BLANK_CHAR;
			shadow_attrs[k] = BLANK_ATTR;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_single_cells();
		test_rectangles();
		test_back_pressure();
		test_drain_pause();
		test_no_idle();
		test_random_traffic(220);

		drain_replies();
		repeat (16) @(negedge clk);
		if (fail_count == 0)
			$display("** text_screen_blitter_core: PASSED **");
		else
			$display("** text_screen_blitter_core: FAILED **");
		$finish;
	end

	// Watchdog
	initial begin
		#25_000_000;
		$display("** text_screen_blitter_core: FAILED **");
		$finish;
	end

endmodule

>>> files.f
sv/tsb_pkg.sv
sv/tsb_cmd_if.sv
sv/tsb_rsp_if.sv
sv/tsb_dp.sv
sv/tsb_ctrl.sv
sv/text_screen_blitter_core.sv
tb/tb_top.sv
